// ----- hdl/segment_tree_range_combine_defines.svh -----
// ----------------------------------------------------------------------------
// Segment tree range combine: assertion macros
// Shared property shorthands for the block's checks, clocked on i_clk and
// held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TREE_RANGE_COMBINE_DEFINES_SVH
`define SEGMENT_TREE_RANGE_COMBINE_DEFINES_SVH

// same-cycle implication
`define STRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("strc check failed");

// next-cycle implication
`define STRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("strc check failed");

`endif

// ----- hdl/strc_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment tree range combine: shared package
// Types, codes, identities and the combining operation used by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package strc_pkg;

    localparam int unsigned LEAVES_DEFAULT = 1024;
    localparam int unsigned DATA_W         = 64;

    // identities of the min and max modes
    localparam logic [DATA_W-1:0] IDENT_MIN = 64'd1000000000000000000;
    localparam logic [DATA_W-1:0] IDENT_MAX = 64'd0 - 64'd1000000000000000000;

    typedef enum logic [1:0] {
        MODE_SUM = 2'd0,
        MODE_MIN = 2'd1,
        MODE_MAX = 2'd2,
        MODE_XOR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REQ_SET    = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic load_req;   // latch the accepted beat
        logic set_leaf;   // write leaf with operand, fetch sibling
        logic rd_leaf;    // fetch leaf for combine
        logic upd_leaf;   // write combined leaf, fetch sibling
        logic up_step;    // write one parent, fetch next sibling
        logic q_init;     // load range bounds and partial results
        logic q_issue;    // fetch boundary nodes of this level
        logic q_acc;      // fold fetched nodes into partial results
        logic q_shift;    // climb one level
        logic clr_step;   // write one node of the sweep
        logic clr_zero;   // sweep writes zero rather than identity
        logic load_out;   // fill output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_req req;
        logic err;
        logic l_lt_r;
        logic l_odd;
        logic r_odd;
        logic at_root;
        logic clr_last;
    } t_sts;

    function automatic logic [DATA_W-1:0] f_identity(input t_mode mode);
        logic [DATA_W-1:0] id;
        case (mode)
            MODE_MIN: id = IDENT_MIN;
            MODE_MAX: id = IDENT_MAX;
            default:  id = '0;
        endcase
        return id;
    endfunction

    function automatic logic [DATA_W-1:0] f_combine(input t_mode mode,
                                                    input logic [DATA_W-1:0] a,
                                                    input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] res;
        case (mode)
            MODE_SUM: res = a + b;
            MODE_MIN: res = ($signed(b) < $signed(a)) ? b : a;
            MODE_MAX: res = ($signed(a) < $signed(b)) ? b : a;
            MODE_XOR: res = a ^ b;
            default:  res = a ^ b;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/segment_tree_range_combine.sv -----
// ----------------------------------------------------------------------------
// Segment tree range combine: top level
// Segment tree over LEAVES signed 64-bit leaves with set, combine-into-leaf,
// half-open range query and clear, under a selectable sum/min/max/xor mode.
// ----------------------------------------------------------------------------
// One request beat gives one result beat; requests are taken one at a time.
// The nodes live in a 2*LEAVES-word RAM with one write and two registered
// read ports, and the memory read latency sets the pace. Set writes the
// leaf and then one parent per tree level on the walk to the root, update
// first reads the leaf, and a range query climbs level by level, fetching
// the boundary nodes and then folding them in. Clear writes one node a
// cycle. After reset the block zeroes the node memory in a sweep and holds
// o_in_stall high until it is done; the mode register may be written at
// any time the block is idle, including during that sweep. A finished
// result waits in the output register while the next request is accepted.
// Changing the mode does not rebuild the tree: clear after a mode change.
// ----------------------------------------------------------------------------
`include "segment_tree_range_combine_defines.svh"

module segment_tree_range_combine #(
    parameter int unsigned LEAVES = strc_pkg::LEAVES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_wdata,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [$clog2(LEAVES)-1:0]   i_position,
    input  logic [$clog2(LEAVES):0]     i_range_end,
    input  logic [strc_pkg::DATA_W-1:0] i_value,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [strc_pkg::DATA_W-1:0] o_combined,
    output logic                        o_status
);

    strc_pkg::t_cmd cmd;
    strc_pkg::t_sts sts;

    strc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    strc_dpath #(
        .LEAVES (LEAVES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_range_end (i_range_end),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_combined  (o_combined),
        .o_status    (o_status)
    );

    // an accepted request closes the input until its result is out
    `STRC_ASSERT_NEXT(a_accept_then_busy, i_in_valid && !o_in_stall, o_in_stall)

    // never overwrite a result still waiting to be taken
    `STRC_ASSERT_NOW(a_load_when_free, cmd.load_out, !o_out_valid || !i_out_stall)

    // a new result appears only through an output load
    `STRC_ASSERT_NEXT(a_valid_from_load, cmd.load_out, o_out_valid)

endmodule

// ----- hdl/strc_ram.sv -----
// ----------------------------------------------------------------------------
// Segment tree range combine: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module strc_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write and read, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hdl/strc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Segment tree range combine: controller
// Sequences the reset sweep, leaf writes with the walk to the root, range
// queries level by level, the clear sweep and the result hand-off.
// ----------------------------------------------------------------------------
module strc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  strc_pkg::t_sts i_sts,
    output strc_pkg::t_cmd o_cmd
);

    typedef enum logic [8:0] {
        S_INIT     = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DISPATCH = 9'b000000100,
        S_U_LEAF   = 9'b000001000,
        S_U_UP     = 9'b000010000,
        S_Q_TEST   = 9'b000100000,
        S_Q_DAT    = 9'b001000000,
        S_CLEAR    = 9'b010000000,
        S_FINISH   = 9'b100000000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_out_valid;
    logic           n_out_valid;
    logic           out_free;
    strc_pkg::t_cmd cmd;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_INIT: begin
                cmd.clr_step = 1'b1;
                cmd.clr_zero = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.err) begin
                    n_state = S_FINISH;
                end else begin
                    case (i_sts.req)
                        strc_pkg::REQ_SET: begin
                            cmd.set_leaf = 1'b1;
                            n_state      = S_U_UP;
                        end
                        strc_pkg::REQ_UPDATE: begin
                            cmd.rd_leaf = 1'b1;
                            n_state     = S_U_LEAF;
                        end
                        strc_pkg::REQ_QUERY: begin
                            cmd.q_init = 1'b1;
                            n_state    = S_Q_TEST;
                        end
                        default: begin
                            n_state = S_CLEAR;
                        end
                    endcase
                end
            end
            S_U_LEAF: begin
                cmd.upd_leaf = 1'b1;
                n_state      = S_U_UP;
            end
            S_U_UP: begin
                cmd.up_step = 1'b1;
                if (i_sts.at_root) begin
                    n_state = S_FINISH;
                end
            end
            S_Q_TEST: begin
                if (!i_sts.l_lt_r) begin
                    n_state = S_FINISH;
                end else if (i_sts.l_odd || i_sts.r_odd) begin
                    cmd.q_issue = 1'b1;
                    n_state     = S_Q_DAT;
                end else begin
                    cmd.q_shift = 1'b1;
                end
            end
            S_Q_DAT: begin
                cmd.q_acc   = 1'b1;
                cmd.q_shift = 1'b1;
                n_state     = S_Q_TEST;
            end
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold result until taken
    always_comb begin
        n_out_valid = (r_out_valid && i_out_stall) || cmd.load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- hdl/strc_dpath.sv -----
// ----------------------------------------------------------------------------
// Segment tree range combine: datapath
// Node memory, request registers, walk pointers, partial results, the
// combining units and the output register.
// ----------------------------------------------------------------------------
module strc_dpath #(
    parameter int unsigned LEAVES = strc_pkg::LEAVES_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_wdata,
    input  logic [1:0]                  i_req_type,
    input  logic [$clog2(LEAVES)-1:0]   i_position,
    input  logic [$clog2(LEAVES):0]     i_range_end,
    input  logic [strc_pkg::DATA_W-1:0] i_value,
    input  strc_pkg::t_cmd              i_cmd,
    output strc_pkg::t_sts              o_sts,
    output logic [strc_pkg::DATA_W-1:0] o_combined,
    output logic                        o_status
);

    localparam int unsigned LW = $clog2(LEAVES);   // leaf index bits
    localparam int unsigned NW = LW + 1;           // node index bits
    localparam int unsigned QW = LW + 2;           // range bound bits
    localparam int unsigned DW = strc_pkg::DATA_W;
    localparam logic [NW-1:0] LEAF_COUNT = NW'(LEAVES);
    localparam logic [QW-1:0] LEAF_BASE  = QW'(LEAVES);

    // configuration and sweep counter
    strc_pkg::t_mode r_mode;
    logic [NW-1:0]   r_cnt;

    // request
    strc_pkg::t_req  r_req;
    logic [LW-1:0]   r_pos;
    logic [LW:0]     r_end;
    logic [DW-1:0]   r_val;
    logic [DW-1:0]   r_ident;
    logic            r_err;
    logic            n_err;

    // walks
    logic [NW-1:0]   r_node;
    logic [DW-1:0]   r_acc;
    logic [QW-1:0]   r_l;
    logic [QW-1:0]   r_r;
    logic [DW-1:0]   r_left;
    logic [DW-1:0]   r_right;
    logic            r_take_l;
    logic            r_take_r;

    // output register
    logic [DW-1:0]   r_out_comb;
    logic            r_out_stat;

    // memory ports
    logic            ram_we;
    logic [NW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [NW-1:0]   ram_raddr_a;
    logic [NW-1:0]   ram_raddr_b;
    logic [DW-1:0]   ram_rdata_a;
    logic [DW-1:0]   ram_rdata_b;

    logic [NW-1:0]   leaf;
    logic [NW-1:0]   parent;
    logic [QW-1:0]   right_node;
    logic [DW-1:0]   c_leaf;
    logic [DW-1:0]   c_up;
    logic [DW-1:0]   c_left;
    logic [DW-1:0]   c_right;
    logic [DW-1:0]   c_final;

    assign leaf       = {1'b1, r_pos};
    assign parent     = {1'b0, r_node[NW-1:1]};
    assign right_node = r_r - QW'(1);

    // combining units
    assign c_leaf  = strc_pkg::f_combine(r_mode, ram_rdata_a, r_val);
    assign c_up    = r_node[0] ? strc_pkg::f_combine(r_mode, ram_rdata_a, r_acc)
                               : strc_pkg::f_combine(r_mode, r_acc, ram_rdata_a);
    assign c_left  = strc_pkg::f_combine(r_mode, r_left, ram_rdata_a);
    assign c_right = strc_pkg::f_combine(r_mode, ram_rdata_b, r_right);
    assign c_final = strc_pkg::f_combine(r_mode, r_left, r_right);

    // bounds check on the incoming beat
    always_comb begin
        case (strc_pkg::t_req'(i_req_type))
            strc_pkg::REQ_SET,
            strc_pkg::REQ_UPDATE: n_err = ({1'b0, i_position} >= LEAF_COUNT);
            strc_pkg::REQ_QUERY:  n_err = ({1'b0, i_position} > i_range_end) ||
                                          (i_range_end > LEAF_COUNT);
            default:              n_err = 1'b0;
        endcase
    end

    // memory port steering
    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_node;
        ram_wdata   = r_acc;
        ram_raddr_a = r_node;
        ram_raddr_b = right_node[NW-1:0];
        if (i_cmd.set_leaf) begin
            ram_we      = 1'b1;
            ram_waddr   = leaf;
            ram_wdata   = r_val;
            ram_raddr_a = {leaf[NW-1:1], ~leaf[0]};
        end else if (i_cmd.rd_leaf) begin
            ram_raddr_a = leaf;
        end else if (i_cmd.upd_leaf) begin
            ram_we      = 1'b1;
            ram_waddr   = r_node;
            ram_wdata   = c_leaf;
            ram_raddr_a = {r_node[NW-1:1], ~r_node[0]};
        end else if (i_cmd.up_step) begin
            ram_we      = 1'b1;
            ram_waddr   = parent;
            ram_wdata   = c_up;
            ram_raddr_a = {parent[NW-1:1], ~parent[0]};
        end else if (i_cmd.q_issue) begin
            ram_raddr_a = r_l[NW-1:0];
        end else if (i_cmd.clr_step) begin
            ram_we      = 1'b1;
            ram_waddr   = r_cnt;
            ram_wdata   = i_cmd.clr_zero ? '0 : r_ident;
        end
    end

    // mode register and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= strc_pkg::MODE_SUM;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= strc_pkg::t_mode'(i_cfg_wdata);
            end
            if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + NW'(1);
            end
        end
    end

    // request, walk and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= strc_pkg::t_req'(i_req_type);
            r_pos   <= i_position;
            r_end   <= i_range_end;
            r_val   <= i_value;
            r_ident <= strc_pkg::f_identity(r_mode);
            r_err   <= n_err;
        end
        if (i_cmd.set_leaf) begin
            r_node <= leaf;
            r_acc  <= r_val;
        end
        if (i_cmd.rd_leaf) begin
            r_node <= leaf;
        end
        if (i_cmd.upd_leaf) begin
            r_acc <= c_leaf;
        end
        if (i_cmd.up_step) begin
            r_acc  <= c_up;
            r_node <= parent;
        end
        if (i_cmd.q_init) begin
            r_l     <= {2'b01, r_pos};
            r_r     <= {1'b0, r_end} + LEAF_BASE;
            r_left  <= r_ident;
            r_right <= r_ident;
        end
        if (i_cmd.q_issue) begin
            r_take_l <= r_l[0];
            r_take_r <= r_r[0];
            r_l      <= r_l + QW'(r_l[0]);
            r_r      <= r_r - QW'(r_r[0]);
        end
        if (i_cmd.q_acc) begin
            if (r_take_l) begin
                r_left <= c_left;
            end
            if (r_take_r) begin
                r_right <= c_right;
            end
        end
        if (i_cmd.q_shift) begin
            r_l <= r_l >> 1;
            r_r <= r_r >> 1;
        end
        if (i_cmd.load_out) begin
            r_out_comb <= (r_req == strc_pkg::REQ_QUERY && !r_err) ? c_final : r_ident;
            r_out_stat <= r_err;
        end
    end

    strc_ram #(
        .WIDTH (DW),
        .DEPTH (2 * LEAVES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_b (ram_rdata_b)
    );

    // status to controller
    assign o_sts.req      = r_req;
    assign o_sts.err      = r_err;
    assign o_sts.l_lt_r   = (r_l < r_r);
    assign o_sts.l_odd    = r_l[0];
    assign o_sts.r_odd    = r_r[0];
    assign o_sts.at_root  = (r_node[NW-1:1] == (NW-1)'(1));
    assign o_sts.clr_last = &r_cnt;

    assign o_combined = r_out_comb;
    assign o_status   = r_out_stat;

endmodule
